// File: design/ddwsp_pkg.sv
// ddwsp_pkg: shared widths, reset values, register and multiplier step codes
// for the wheel speed controller. No dependencies.
// Used by ddwsp_ctrl, ddwsp_dpath and diff_drive_wheel_speed_p_control.
package ddwsp_pkg;

    localparam int ENCODER_BITS_DEF = 12;
    localparam int DUTY_BITS_DEF    = 8;

    localparam int GAIN_W     = 16;
    localparam int DB_W       = 7;
    localparam int COEF_W     = 18;
    localparam int LIMIT_W    = 12;
    localparam int STICK_W    = 8;
    localparam int STEP_OUT_W = 13;
    localparam int PROD_FRAC  = 24;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STICK_DEADBAND = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FORWARD_COEF   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_COEF      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_COEF     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_UNWRAP_LIMIT   = 3'd5;

    localparam logic [GAIN_W-1:0]  GAIN_P_RST         = 16'd256;
    localparam logic [DB_W-1:0]    STICK_DEADBAND_RST = 7'd10;
    localparam logic [COEF_W-1:0]  FORWARD_COEF_RST   = 18'd1024;
    localparam logic [COEF_W-1:0]  TURN_COEF_RST      = 18'd15061;
    localparam logic [COEF_W-1:0]  SPEED_COEF_RST     = 18'd100531;
    localparam logic [LIMIT_W-1:0] UNWRAP_LIMIT_RST   = 12'd2000;

    localparam int MUL_SEL_W = 3;
    localparam logic [MUL_SEL_W-1:0] MUL_FWD   = 3'd0;
    localparam logic [MUL_SEL_W-1:0] MUL_TURN  = 3'd1;
    localparam logic [MUL_SEL_W-1:0] MUL_SPD_R = 3'd2;
    localparam logic [MUL_SEL_W-1:0] MUL_SPD_L = 3'd3;
    localparam logic [MUL_SEL_W-1:0] MUL_GHI_R = 3'd4;
    localparam logic [MUL_SEL_W-1:0] MUL_GLO_R = 3'd5;
    localparam logic [MUL_SEL_W-1:0] MUL_GHI_L = 3'd6;
    localparam logic [MUL_SEL_W-1:0] MUL_GLO_L = 3'd7;

    localparam int CNT_W = 4;
    localparam logic [CNT_W-1:0] MUL_STEPS = 4'd8;

    typedef struct packed {
        logic                 capture;
        logic                 prep;
        logic                 mul_en;
        logic [MUL_SEL_W-1:0] mul_sel;
        logic                 out_load;
        logic                 out_zero;
    } t_dp_cmd;

endpackage

// File: design/ddwsp_ctrl.sv
// ddwsp_ctrl: sequencer for one control tick (capture, unwrap, eight multiplies,
// result load) and the output word handshake. Depends on ddwsp_pkg.
module ddwsp_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output ddwsp_pkg::t_dp_cmd  o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_PREP = 2'd1;
    localparam logic [1:0] S_MUL  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]                  r_state, n_state;
    logic [ddwsp_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic                        r_primed, n_primed;
    logic                        r_zero, n_zero;
    logic                        r_out_valid, n_out_valid;
    logic                        w_accept;
    logic                        w_out_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;

    always_comb begin
        o_cmd          = '0;
        o_cmd.capture  = w_accept;
        o_cmd.prep     = (r_state == S_PREP);
        o_cmd.mul_en   = (r_state == S_MUL) && (r_cnt != ddwsp_pkg::MUL_STEPS);
        o_cmd.mul_sel  = r_cnt[ddwsp_pkg::MUL_SEL_W-1:0];
        o_cmd.out_load = (r_state == S_DONE) && w_out_free;
        o_cmd.out_zero = r_zero;
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_primed    = r_primed;
        n_zero      = r_zero;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                n_cnt    = '0;
                n_zero   = !r_primed;
                n_primed = 1'b1;
                n_state  = r_primed ? S_MUL : S_DONE;
            end
            S_MUL: begin
                if (r_cnt == ddwsp_pkg::MUL_STEPS) begin
                    n_state = S_DONE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_primed    <= 1'b0;
            r_zero      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_primed    <= n_primed;
            r_zero      <= n_zero;
            r_out_valid <= n_out_valid;
        end
    end

    a_accept_to_prep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state == S_PREP)
        else $error("accepted word did not enter unwrap step");

    a_first_tick_skips: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PREP && !r_primed) |=> (r_state == S_DONE && r_zero))
        else $error("priming tick did not go straight to result");

    a_mul_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL && r_cnt == ddwsp_pkg::MUL_STEPS) |=> r_state == S_DONE)
        else $error("multiply sequence overran");

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> r_out_valid)
        else $error("result load lost");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("pending result overwritten");

endmodule

// File: design/ddwsp_dpath.sv
// ddwsp_dpath: config registers, encoder unwrap, stick deadband, shared signed
// multiplier with accumulate, and duty split into the output word registers.
// Depends on ddwsp_pkg; driven by commands from ddwsp_ctrl.
module ddwsp_dpath #(
    parameter int ENCODER_BITS = ddwsp_pkg::ENCODER_BITS_DEF,
    parameter int DUTY_BITS    = ddwsp_pkg::DUTY_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  ddwsp_pkg::t_dp_cmd                     i_cmd,
    input  logic                                   i_cfg_wr_en,
    input  logic [ddwsp_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [ddwsp_pkg::CFG_DATA_W-1:0]       i_cfg_wdata,
    input  logic [ENCODER_BITS-1:0]                i_right_reading,
    input  logic [ENCODER_BITS-1:0]                i_left_reading,
    input  logic signed [ddwsp_pkg::STICK_W-1:0]   i_stick_lx,
    input  logic signed [ddwsp_pkg::STICK_W-1:0]   i_stick_ly,
    input  logic signed [ddwsp_pkg::STICK_W-1:0]   i_stick_rx,
    input  logic                                   i_pad_connected,
    output logic [DUTY_BITS-1:0]                   o_right_fwd_duty,
    output logic [DUTY_BITS-1:0]                   o_right_rev_duty,
    output logic [DUTY_BITS-1:0]                   o_left_fwd_duty,
    output logic [DUTY_BITS-1:0]                   o_left_rev_duty,
    output logic signed [ddwsp_pkg::STEP_OUT_W-1:0] o_right_step,
    output logic signed [ddwsp_pkg::STEP_OUT_W-1:0] o_left_step
);

    localparam int SW    = ENCODER_BITS + 1;
    localparam int DW    = ((ENCODER_BITS > ddwsp_pkg::LIMIT_W) ?
                            ENCODER_BITS : ddwsp_pkg::LIMIT_W) + 2;
    localparam int EW    = ddwsp_pkg::COEF_W + SW + 2;
    localparam int LO_W  = ddwsp_pkg::COEF_W;
    localparam int HI_W  = EW - LO_W;
    localparam int MA    = ddwsp_pkg::COEF_W + 1;
    localparam int MB    = (HI_W > ddwsp_pkg::GAIN_W + 1) ? HI_W : ddwsp_pkg::GAIN_W + 1;
    localparam int MP    = MA + MB;
    localparam int PW    = EW + ddwsp_pkg::GAIN_W + 1;
    localparam int MAG_W = PW - ddwsp_pkg::PROD_FRAC;
    localparam int SK    = ddwsp_pkg::STICK_W;

    localparam logic [DW-1:0]    ENC_MOD  = DW'(1) << ENCODER_BITS;
    localparam logic [MAG_W-1:0] DUTY_MAX = MAG_W'((1 << DUTY_BITS) - 1);

    // config registers
    logic [ddwsp_pkg::GAIN_W-1:0]  r_gain;
    logic [ddwsp_pkg::DB_W-1:0]    r_db;
    logic [ddwsp_pkg::COEF_W-1:0]  r_fwd_coef;
    logic [ddwsp_pkg::COEF_W-1:0]  r_turn_coef;
    logic [ddwsp_pkg::COEF_W-1:0]  r_spd_coef;
    logic [ddwsp_pkg::LIMIT_W-1:0] r_limit;

    // captured word
    logic [ENCODER_BITS-1:0] r_rr, r_lr;
    logic signed [SK-1:0]    r_lx, r_ly, r_rx;
    logic                    r_pad;

    // tick state and working registers
    logic [ENCODER_BITS-1:0] r_prev_r, r_prev_l;
    logic signed [SW-1:0]    r_sr, r_sl;
    logic signed [SK-1:0]    r_fcmd, r_tcmd;
    logic signed [EW-1:0]    r_fpart, r_tpart, r_err_r, r_err_l;
    logic signed [PW-1:0]    r_hi, r_prod_r, r_prod_l;

    // shared multiplier
    logic signed [MA-1:0]              w_a;
    logic signed [MB-1:0]              w_b;
    logic signed [MP-1:0]              r_prod;
    logic [ddwsp_pkg::MUL_SEL_W-1:0]   r_psel;
    logic                              r_pv;

    logic [2*DUTY_BITS-1:0] w_duty_r, w_duty_l;

    function automatic logic signed [SW-1:0] f_unwrap(
        input logic [ENCODER_BITS-1:0]         now,
        input logic [ENCODER_BITS-1:0]         before_val,
        input logic [ddwsp_pkg::LIMIT_W-1:0]   lim
    );
        logic signed [DW-1:0] d;
        logic signed [DW-1:0] l;
        d = $signed(DW'(now)) - $signed(DW'(before_val));
        l = $signed(DW'(lim));
        if (d < -l) begin
            d = d + $signed(ENC_MOD);
        end else if (d > l) begin
            d = d - $signed(ENC_MOD);
        end
        return SW'(d);
    endfunction

    function automatic logic f_past_db(
        input logic signed [SK-1:0]          v,
        input logic [ddwsp_pkg::DB_W-1:0]    db
    );
        logic signed [SK:0] x;
        logic signed [SK:0] t;
        x = $signed({v[SK-1], v});
        t = $signed((SK+1)'(db));
        return (x >= t) || (x <= -t);
    endfunction

    function automatic logic [2*DUTY_BITS-1:0] f_duty(
        input logic signed [PW-1:0] p,
        input logic                 flip
    );
        logic                 neg;
        logic [PW-1:0]        mag;
        logic [MAG_W-1:0]     sh;
        logic [DUTY_BITS-1:0] d;
        neg = p[PW-1];
        mag = neg ? $unsigned(-p) : $unsigned(p);
        sh  = mag[PW-1:ddwsp_pkg::PROD_FRAC];
        d   = (sh > DUTY_MAX) ? DUTY_MAX[DUTY_BITS-1:0] : sh[DUTY_BITS-1:0];
        if (neg ^ flip) begin
            return {{DUTY_BITS{1'b0}}, d};
        end else begin
            return {d, {DUTY_BITS{1'b0}}};
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain      <= ddwsp_pkg::GAIN_P_RST;
            r_db        <= ddwsp_pkg::STICK_DEADBAND_RST;
            r_fwd_coef  <= ddwsp_pkg::FORWARD_COEF_RST;
            r_turn_coef <= ddwsp_pkg::TURN_COEF_RST;
            r_spd_coef  <= ddwsp_pkg::SPEED_COEF_RST;
            r_limit     <= ddwsp_pkg::UNWRAP_LIMIT_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                ddwsp_pkg::CFG_GAIN_P: begin
                    r_gain <= i_cfg_wdata[ddwsp_pkg::GAIN_W-1:0];
                end
                ddwsp_pkg::CFG_STICK_DEADBAND: begin
                    r_db <= i_cfg_wdata[ddwsp_pkg::DB_W-1:0];
                end
                ddwsp_pkg::CFG_FORWARD_COEF: begin
                    r_fwd_coef <= i_cfg_wdata[ddwsp_pkg::COEF_W-1:0];
                end
                ddwsp_pkg::CFG_TURN_COEF: begin
                    r_turn_coef <= i_cfg_wdata[ddwsp_pkg::COEF_W-1:0];
                end
                ddwsp_pkg::CFG_SPEED_COEF: begin
                    r_spd_coef <= i_cfg_wdata[ddwsp_pkg::COEF_W-1:0];
                end
                ddwsp_pkg::CFG_UNWRAP_LIMIT: begin
                    r_limit <= i_cfg_wdata[ddwsp_pkg::LIMIT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_rr  <= i_right_reading;
            r_lr  <= i_left_reading;
            r_lx  <= i_stick_lx;
            r_ly  <= i_stick_ly;
            r_rx  <= i_stick_rx;
            r_pad <= i_pad_connected;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_r <= '0;
            r_prev_l <= '0;
        end else if (i_cmd.prep) begin
            r_prev_r <= r_rr;
            r_prev_l <= r_lr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_sr   <= f_unwrap(r_rr, r_prev_r, r_limit);
            r_sl   <= f_unwrap(r_lr, r_prev_l, r_limit);
            r_fcmd <= (r_pad && f_past_db(r_lx, r_db)) ? r_ly : '0;
            r_tcmd <= (r_pad && f_past_db(r_ly, r_db)) ? r_rx : '0;
        end
    end

    always_comb begin
        w_a = '0;
        w_b = '0;
        case (i_cmd.mul_sel)
            ddwsp_pkg::MUL_FWD: begin
                w_a = $signed(MA'(r_fwd_coef));
                w_b = MB'(r_fcmd);
            end
            ddwsp_pkg::MUL_TURN: begin
                w_a = $signed(MA'(r_turn_coef));
                w_b = MB'(r_tcmd);
            end
            ddwsp_pkg::MUL_SPD_R: begin
                w_a = $signed(MA'(r_spd_coef));
                w_b = MB'(r_sr);
            end
            ddwsp_pkg::MUL_SPD_L: begin
                w_a = $signed(MA'(r_spd_coef));
                w_b = MB'(r_sl);
            end
            ddwsp_pkg::MUL_GHI_R: begin
                w_a = $signed(MA'(r_gain));
                w_b = MB'($signed(r_err_r[EW-1:LO_W]));
            end
            ddwsp_pkg::MUL_GLO_R: begin
                w_a = $signed(MA'(r_err_r[LO_W-1:0]));
                w_b = $signed(MB'(r_gain));
            end
            ddwsp_pkg::MUL_GHI_L: begin
                w_a = $signed(MA'(r_gain));
                w_b = MB'($signed(r_err_l[EW-1:LO_W]));
            end
            ddwsp_pkg::MUL_GLO_L: begin
                w_a = $signed(MA'(r_err_l[LO_W-1:0]));
                w_b = $signed(MB'(r_gain));
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= i_cmd.mul_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod <= w_a * w_b;
            r_psel <= i_cmd.mul_sel;
        end
    end

    // product of the previous step lands in its accumulator
    always_ff @(posedge i_clk) begin
        if (r_pv) begin
            case (r_psel)
                ddwsp_pkg::MUL_FWD: begin
                    r_fpart <= EW'(r_prod);
                end
                ddwsp_pkg::MUL_TURN: begin
                    r_tpart <= EW'(r_prod);
                end
                ddwsp_pkg::MUL_SPD_R: begin
                    r_err_r <= r_fpart + r_tpart - EW'(r_prod);
                end
                ddwsp_pkg::MUL_SPD_L: begin
                    r_err_l <= r_fpart - r_tpart - EW'(r_prod);
                end
                ddwsp_pkg::MUL_GHI_R, ddwsp_pkg::MUL_GHI_L: begin
                    r_hi <= PW'(r_prod);
                end
                ddwsp_pkg::MUL_GLO_R: begin
                    r_prod_r <= (r_hi <<< LO_W) + PW'(r_prod);
                end
                ddwsp_pkg::MUL_GLO_L: begin
                    r_prod_l <= (r_hi <<< LO_W) + PW'(r_prod);
                end
                default: begin
                end
            endcase
        end
    end

    // right wheel drive is negated
    assign w_duty_r = f_duty(r_prod_r, 1'b1);
    assign w_duty_l = f_duty(r_prod_l, 1'b0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (i_cmd.out_zero) begin
                o_right_fwd_duty <= '0;
                o_right_rev_duty <= '0;
                o_left_fwd_duty  <= '0;
                o_left_rev_duty  <= '0;
                o_right_step     <= '0;
                o_left_step      <= '0;
            end else begin
                o_right_fwd_duty <= w_duty_r[2*DUTY_BITS-1:DUTY_BITS];
                o_right_rev_duty <= w_duty_r[DUTY_BITS-1:0];
                o_left_fwd_duty  <= w_duty_l[2*DUTY_BITS-1:DUTY_BITS];
                o_left_rev_duty  <= w_duty_l[DUTY_BITS-1:0];
                o_right_step     <= ddwsp_pkg::STEP_OUT_W'(r_sr);
                o_left_step      <= ddwsp_pkg::STEP_OUT_W'(r_sl);
            end
        end
    end

endmodule

// File: design/diff_drive_wheel_speed_p_control.sv
// Differential-drive proportional wheel speed controller. One input word per control
// tick: two absolute encoder readings, three stick axes and a pad-present flag; one
// output word: forward/reverse PWM duties per wheel and the unwrapped encoder steps.
// The first word after reset only primes the stored readings. It returns all zeros.
// Every later word passes from acceptance through an unwrap step, eight passes
// through one shared 19 x 17 bit signed multiplier (speed, target and gain products,
// the gain product in two halves), a step for the last product to land, a result
// step and an idle step in which the next word is taken. A finished word waits in
// the output register while the next input word is taken. If that register is still
// full when the next result is ready, the block holds in its result step and does
// not accept input. Configuration registers are written through a plain write port
// with indexes 0 gain_p, 1 stick_deadband, 2 forward_coef, 3 turn_coef,
// 4 speed_coef, 5 unwrap_limit; other indexes are ignored. Depends on ddwsp_pkg,
// ddwsp_ctrl and ddwsp_dpath.
module diff_drive_wheel_speed_p_control #(
    parameter int ENCODER_BITS = ddwsp_pkg::ENCODER_BITS_DEF,
    parameter int DUTY_BITS    = ddwsp_pkg::DUTY_BITS_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_wr_en,
    input  logic [ddwsp_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [ddwsp_pkg::CFG_DATA_W-1:0]        i_cfg_wdata,
    input  logic                                    i_in_valid,
    output logic                                    o_in_ready,
    input  logic [ENCODER_BITS-1:0]                 i_right_reading,
    input  logic [ENCODER_BITS-1:0]                 i_left_reading,
    input  logic signed [ddwsp_pkg::STICK_W-1:0]    i_stick_lx,
    input  logic signed [ddwsp_pkg::STICK_W-1:0]    i_stick_ly,
    input  logic signed [ddwsp_pkg::STICK_W-1:0]    i_stick_rx,
    input  logic                                    i_pad_connected,
    output logic                                    o_out_valid,
    input  logic                                    i_out_ready,
    output logic [DUTY_BITS-1:0]                    o_right_fwd_duty,
    output logic [DUTY_BITS-1:0]                    o_right_rev_duty,
    output logic [DUTY_BITS-1:0]                    o_left_fwd_duty,
    output logic [DUTY_BITS-1:0]                    o_left_rev_duty,
    output logic signed [ddwsp_pkg::STEP_OUT_W-1:0] o_right_step,
    output logic signed [ddwsp_pkg::STEP_OUT_W-1:0] o_left_step
);

    ddwsp_pkg::t_dp_cmd w_cmd;

    ddwsp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd)
    );

    ddwsp_dpath #(
        .ENCODER_BITS (ENCODER_BITS),
        .DUTY_BITS    (DUTY_BITS)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_right_reading  (i_right_reading),
        .i_left_reading   (i_left_reading),
        .i_stick_lx       (i_stick_lx),
        .i_stick_ly       (i_stick_ly),
        .i_stick_rx       (i_stick_rx),
        .i_pad_connected  (i_pad_connected),
        .o_right_fwd_duty (o_right_fwd_duty),
        .o_right_rev_duty (o_right_rev_duty),
        .o_left_fwd_duty  (o_left_fwd_duty),
        .o_left_rev_duty  (o_left_rev_duty),
        .o_right_step     (o_right_step),
        .o_left_step      (o_left_step)
    );

endmodule

// File: tb/sv/diff_drive_wheel_speed_p_control_tb.sv
// Self-checking bench for diff_drive_wheel_speed_p_control: a directed table, then
// random control ticks over several register settings, checked against a local predictor.
// Depends on ddwsp_pkg and the RTL of the controller.
module diff_drive_wheel_speed_p_control_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ddwsp_pkg::*;

    localparam int ENC_W          = ENCODER_BITS_DEF;
    localparam int DUTY_W         = DUTY_BITS_DEF;
    localparam int ENC_SPAN       = 1 << ENC_W;
    localparam int DUTY_TOP       = (1 << DUTY_W) - 1;
    localparam int CFG_FULL       = (1 << CFG_DATA_W) - 1;
    localparam int N_ROWS         = 16;
    localparam int N_PHASES       = 8;
    localparam int WORDS_PER_PH   = 204;
    localparam int SETTLE_CYCLES  = 16;
    localparam int LONG_HOLD      = 300;
    localparam int REPORT_LIMIT   = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [ENC_W-1:0]          right_reading;
        logic [ENC_W-1:0]          left_reading;
        logic signed [STICK_W-1:0] stick_lx;
        logic signed [STICK_W-1:0] stick_ly;
        logic signed [STICK_W-1:0] stick_rx;
        logic                      pad_connected;
    } wheel_word_t;

    typedef struct packed {
        logic [DUTY_W-1:0]            right_fwd_duty;
        logic [DUTY_W-1:0]            right_rev_duty;
        logic [DUTY_W-1:0]            left_fwd_duty;
        logic [DUTY_W-1:0]            left_rev_duty;
        logic signed [STEP_OUT_W-1:0] right_step;
        logic signed [STEP_OUT_W-1:0] left_step;
    } duty_word_t;

    typedef struct packed {
        wheel_word_t w;
        logic        has_exp;
        duty_word_t  want;
    } steer_row_t;

    localparam logic [$bits(duty_word_t):0] UNCHECKED = '0;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]           i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0]          i_cfg_wdata = '0;
    logic                           i_in_valid = 1'b0;
    logic                           o_in_ready;
    logic [ENC_W-1:0]               i_right_reading = '0;
    logic [ENC_W-1:0]               i_left_reading = '0;
    logic signed [STICK_W-1:0]      i_stick_lx = '0;
    logic signed [STICK_W-1:0]      i_stick_ly = '0;
    logic signed [STICK_W-1:0]      i_stick_rx = '0;
    logic                           i_pad_connected = 1'b0;
    logic                           o_out_valid;
    logic                           i_out_ready = 1'b0;
    logic [DUTY_W-1:0]              o_right_fwd_duty;
    logic [DUTY_W-1:0]              o_right_rev_duty;
    logic [DUTY_W-1:0]              o_left_fwd_duty;
    logic [DUTY_W-1:0]              o_left_rev_duty;
    logic signed [STEP_OUT_W-1:0]   o_right_step;
    logic signed [STEP_OUT_W-1:0]   o_left_step;

    // predictor copy of registers and encoder history
    int             cfg_gain     = int'(GAIN_P_RST);
    int             cfg_deadband = int'(STICK_DEADBAND_RST);
    int             cfg_forward  = int'(FORWARD_COEF_RST);
    int             cfg_turn     = int'(TURN_COEF_RST);
    int             cfg_speed    = int'(SPEED_COEF_RST);
    int             cfg_limit    = int'(UNWRAP_LIMIT_RST);
    logic [ENC_W-1:0] enc_prev_right = '0;
    logic [ENC_W-1:0] enc_prev_left  = '0;
    bit             enc_primed = 1'b0;

    duty_word_t     pending_duties[$];
    steer_row_t     steer_rows[0:N_ROWS-1];
    bit             idle_on = 1'b1;
    int             out_hold_req = 0;
    int             words_sent = 0;
    int             results_seen = 0;
    int             failures = 0;
    int             settings_loaded = 0;

    diff_drive_wheel_speed_p_control dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_right_reading  (i_right_reading),
        .i_left_reading   (i_left_reading),
        .i_stick_lx       (i_stick_lx),
        .i_stick_ly       (i_stick_ly),
        .i_stick_rx       (i_stick_rx),
        .i_pad_connected  (i_pad_connected),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_right_fwd_duty (o_right_fwd_duty),
        .o_right_rev_duty (o_right_rev_duty),
        .o_left_fwd_duty  (o_left_fwd_duty),
        .o_left_rev_duty  (o_left_rev_duty),
        .o_right_step     (o_right_step),
        .o_left_step      (o_left_step)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #4_000_000;
        $display("diff_drive_wheel_speed_p_control_tb: FAIL");
        $finish;
    end

    function automatic int unwrap_step(int now, int was);
        int d;
        d = now - was;
        if (d < -cfg_limit) begin
            d = d + ENC_SPAN;
        end else if (d > cfg_limit) begin
            d = d - ENC_SPAN;
        end
        return d;
    endfunction

    // returns {fwd, rev}
    function automatic logic [2*DUTY_W-1:0] split_drive(longint err, bit invert);
        longint prod;
        longint mag;
        bit     neg;
        prod = err * longint'(cfg_gain);
        neg = (prod < 0);
        mag = neg ? -prod : prod;
        mag = mag >> PROD_FRAC;
        if (mag > DUTY_TOP) begin
            mag = DUTY_TOP;
        end
        if (invert) begin
            neg = !neg;
        end
        return neg ? {{DUTY_W{1'b0}}, mag[DUTY_W-1:0]} : {mag[DUTY_W-1:0], {DUTY_W{1'b0}}};
    endfunction

    function automatic duty_word_t predict_duties(wheel_word_t w);
        duty_word_t r;
        int         sr;
        int         sl;
        int         lx;
        int         ly;
        int         rx;
        int         fwd_cmd;
        int         turn_cmd;
        longint     fpart;
        longint     tpart;
        r = '0;
        if (!enc_primed) begin
            enc_prev_right = w.right_reading;
            enc_prev_left = w.left_reading;
            enc_primed = 1'b1;
            return r;
        end
        sr = unwrap_step(w.right_reading, enc_prev_right);
        sl = unwrap_step(w.left_reading, enc_prev_left);
        enc_prev_right = w.right_reading;
        enc_prev_left = w.left_reading;
        lx = $signed(w.stick_lx);
        ly = $signed(w.stick_ly);
        rx = $signed(w.stick_rx);
        fwd_cmd = 0;
        turn_cmd = 0;
        if (w.pad_connected) begin
            if (lx >= cfg_deadband || lx <= -cfg_deadband) begin
                fwd_cmd = ly;
            end
            if (ly >= cfg_deadband || ly <= -cfg_deadband) begin
                turn_cmd = rx;
            end
        end
        fpart = longint'(cfg_forward) * fwd_cmd;
        tpart = longint'(cfg_turn) * turn_cmd;
        {r.right_fwd_duty, r.right_rev_duty} =
            split_drive(fpart + tpart - longint'(cfg_speed) * sr, 1'b1);
        {r.left_fwd_duty, r.left_rev_duty} =
            split_drive(fpart - tpart - longint'(cfg_speed) * sl, 1'b0);
        r.right_step = sr[STEP_OUT_W-1:0];
        r.left_step = sl[STEP_OUT_W-1:0];
        return r;
    endfunction

    // mostly steps below the rollover limit, some right at it, some jumps anywhere
    function automatic logic [ENC_W-1:0] next_reading(int was);
        int stepv;
        int reach;
        reach = (cfg_limit < 300) ? cfg_limit : 300;
        case ($urandom_range(0, 9))
            0: begin
                return $urandom_range(0, ENC_SPAN - 1);
            end
            1, 2: begin
                stepv = cfg_limit + $urandom_range(0, 4) - 2;
            end
            default: begin
                stepv = $urandom_range(0, reach + 2);
            end
        endcase
        if ($urandom_range(0, 1)) begin
            stepv = -stepv;
        end
        return (was + stepv) & (ENC_SPAN - 1);
    endfunction

    function automatic logic [STICK_W-1:0] pick_stick();
        int v;
        if ($urandom_range(0, 3) == 0) begin
            v = cfg_deadband + $urandom_range(0, 2) - 1;
            if ($urandom_range(0, 1)) begin
                v = -v;
            end
            if (v > 127) begin
                v = 127;
            end
            if (v < -128) begin
                v = -128;
            end
        end else begin
            v = $urandom_range(0, 255) - 128;
        end
        return v[STICK_W-1:0];
    endfunction

    task automatic send_word(input wheel_word_t w, input bit has_exp, input duty_word_t typed);
        duty_word_t want;
        int         gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 8);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_right_reading <= w.right_reading;
        i_left_reading  <= w.left_reading;
        i_stick_lx      <= w.stick_lx;
        i_stick_ly      <= w.stick_ly;
        i_stick_rx      <= w.stick_rx;
        i_pad_connected <= w.pad_connected;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        want = predict_duties(w);
        if (has_exp) begin
            want = typed;
        end
        pending_duties.push_back(want);
        words_sent++;
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_duties.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
        logic [CFG_DATA_W-1:0] d;
        d = data[CFG_DATA_W-1:0];
        i_cfg_wr_en <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= d;
        @(posedge i_clk);
        case (idx)
            CFG_GAIN_P:         cfg_gain     = d[GAIN_W-1:0];
            CFG_STICK_DEADBAND: cfg_deadband = d[DB_W-1:0];
            CFG_FORWARD_COEF:   cfg_forward  = d[COEF_W-1:0];
            CFG_TURN_COEF:      cfg_turn     = d[COEF_W-1:0];
            CFG_SPEED_COEF:     cfg_speed    = d[COEF_W-1:0];
            CFG_UNWRAP_LIMIT:   cfg_limit    = d[LIMIT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic load_settings(input int g, input int db, input int fc, input int tc,
                                 input int sc, input int lim);
        write_reg(CFG_GAIN_P, g);
        write_reg(CFG_STICK_DEADBAND, db);
        write_reg(CFG_FORWARD_COEF, fc);
        write_reg(CFG_TURN_COEF, tc);
        write_reg(CFG_SPEED_COEF, sc);
        write_reg(CFG_UNWRAP_LIMIT, lim);
        // spare indexes must not disturb anything
        write_reg(CFG_IDX_SPARE_LO, $urandom_range(0, CFG_FULL));
        write_reg(CFG_IDX_SPARE_HI, $urandom_range(0, CFG_FULL));
        i_cfg_wr_en <= 1'b0;
        settings_loaded++;
    endtask

    // output side: random stall bursts plus one long hold-off
    initial begin : out_side
        int hold_left;
        int stall_left;
        hold_left = 0;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (out_hold_req != 0) begin
                hold_left = out_hold_req;
                out_hold_req = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 7);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        duty_word_t got;
        duty_word_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = {o_right_fwd_duty, o_right_rev_duty, o_left_fwd_duty, o_left_rev_duty,
                   o_right_step, o_left_step};
            results_seen++;
            if (pending_duties.size() == 0) begin
                failures++;
                if (failures <= REPORT_LIMIT) begin
                    $display("%0t: unexpected word rf=%0d rr=%0d lf=%0d lr=%0d rs=%0d ls=%0d",
                             $realtime, got.right_fwd_duty, got.right_rev_duty,
                             got.left_fwd_duty, got.left_rev_duty,
                             got.right_step, got.left_step);
                end
            end else begin
                want = pending_duties.pop_front();
                if (got !== want) begin
                    failures++;
                    if (failures <= REPORT_LIMIT) begin
                        $display("%0t: mismatch want rf=%0d rr=%0d lf=%0d lr=%0d rs=%0d ls=%0d",
                                 $realtime, want.right_fwd_duty, want.right_rev_duty,
                                 want.left_fwd_duty, want.left_rev_duty,
                                 want.right_step, want.left_step);
                        $display("    got rf=%0d rr=%0d lf=%0d lr=%0d rs=%0d ls=%0d",
                                 got.right_fwd_duty, got.right_rev_duty,
                                 got.left_fwd_duty, got.left_rev_duty,
                                 got.right_step, got.left_step);
                    end
                end
            end
        end
    end

    initial begin : stimulus
        int          g;
        int          db;
        int          fc;
        int          tc;
        int          sc;
        int          lim;
        logic [ENC_W-1:0] gen_right;
        logic [ENC_W-1:0] gen_left;
        wheel_word_t w;

        // rr, lr, lx, ly, rx, pad | checked, rf, rr, lf, lr, right step, left step
        steer_rows[0]  = {12'd4095, 12'd0, 8'sd0, 8'sd0, 8'sd0, 1'b1, 1'b1, 58'd0};
        steer_rows[1]  = {12'd4095, 12'd0, 8'h80, 8'sd127, 8'h80, 1'b0, 1'b1, 58'd0};
        steer_rows[2]  = {12'd0, 12'd4095, 8'sd0, 8'sd0, 8'sd0, 1'b0,
                          1'b1, 8'd1, 8'd0, 8'd1, 8'd0, 13'sd1, -13'sd1};
        steer_rows[3]  = {12'd2000, 12'd4095, 8'sd0, 8'sd0, 8'sd0, 1'b0,
                          1'b1, 8'd255, 8'd0, 8'd0, 8'd0, 13'sd2000, 13'sd0};
        steer_rows[4]  = {12'd4095, 12'd4095, 8'sd0, 8'sd0, 8'sd0, 1'b0, UNCHECKED};
        steer_rows[5]  = {12'd2095, 12'd2095, 8'sd0, 8'sd0, 8'sd0, 1'b0, UNCHECKED};
        steer_rows[6]  = {12'd95, 12'd94, 8'sd0, 8'sd0, 8'sd0, 1'b0, UNCHECKED};
        steer_rows[7]  = {12'd95, 12'd94, 8'sd10, 8'sd127, 8'h80, 1'b1, UNCHECKED};
        steer_rows[8]  = {12'd95, 12'd94, 8'sd9, 8'sd127, 8'sd127, 1'b1, UNCHECKED};
        steer_rows[9]  = {12'd95, 12'd94, -8'sd10, 8'h80, 8'sd127, 1'b1, UNCHECKED};
        steer_rows[10] = {12'd95, 12'd94, -8'sd9, -8'sd9, 8'h80, 1'b1, UNCHECKED};
        steer_rows[11] = {12'd95, 12'd94, 8'h80, 8'sd10, 8'h80, 1'b1, UNCHECKED};
        steer_rows[12] = {12'd95, 12'd94, 8'sd127, -8'sd10, 8'sd127, 1'b1, UNCHECKED};
        steer_rows[13] = {12'd95, 12'd94, 8'sd127, 8'h80, 8'h80, 1'b0, UNCHECKED};
        steer_rows[14] = {12'd1234, 12'd3000, 8'h80, 8'h80, 8'h80, 1'b1, UNCHECKED};
        steer_rows[15] = {12'd0, 12'd0, 8'sd127, 8'sd127, 8'sd127, 1'b1, UNCHECKED};

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < N_ROWS; i++) begin
            send_word(steer_rows[i].w, steer_rows[i].has_exp, steer_rows[i].want);
        end
        settle();
        gen_right = enc_prev_right;
        gen_left = enc_prev_left;

        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: begin
                    g = 0; db = 0; fc = 0; tc = 0; sc = 0; lim = 0;
                end
                1: begin
                    g = CFG_FULL; db = CFG_FULL; fc = CFG_FULL;
                    tc = CFG_FULL; sc = CFG_FULL; lim = CFG_FULL;
                end
                2: begin
                    g = 65535; db = STICK_DEADBAND_RST; fc = FORWARD_COEF_RST;
                    tc = TURN_COEF_RST; sc = SPEED_COEF_RST; lim = UNWRAP_LIMIT_RST;
                end
                3, 5: begin
                    g = $urandom_range(0, 1023); db = $urandom_range(0, 40);
                    fc = $urandom_range(0, 40000); tc = $urandom_range(0, 40000);
                    sc = $urandom_range(0, 3000); lim = $urandom_range(0, ENC_SPAN - 1);
                end
                4, 6: begin
                    g = $urandom_range(0, CFG_FULL); db = $urandom_range(0, CFG_FULL);
                    fc = $urandom_range(0, CFG_FULL); tc = $urandom_range(0, CFG_FULL);
                    sc = $urandom_range(0, CFG_FULL); lim = $urandom_range(0, CFG_FULL);
                end
                default: begin
                    g = GAIN_P_RST; db = STICK_DEADBAND_RST; fc = FORWARD_COEF_RST;
                    tc = TURN_COEF_RST; sc = SPEED_COEF_RST; lim = UNWRAP_LIMIT_RST;
                    idle_on = 1'b0;
                end
            endcase
            load_settings(g, db, fc, tc, sc, lim);
            if (ph == 2) begin
                out_hold_req = LONG_HOLD;
            end
            for (int n = 0; n < WORDS_PER_PH; n++) begin
                gen_right = next_reading(gen_right);
                gen_left = next_reading(gen_left);
                w.right_reading = gen_right;
                w.left_reading = gen_left;
                w.stick_lx = pick_stick();
                w.stick_ly = pick_stick();
                w.stick_rx = pick_stick();
                w.pad_connected = ($urandom_range(0, 9) != 0);
                send_word(w, 1'b0, '0);
            end
            settle();
        end

        if (pending_duties.size() != 0) begin
            failures++;
        end
        $display("ran %0d words (%0d from the table) across %0d register settings",
                 words_sent, N_ROWS, settings_loaded);
        $display("checked %0d result words, %0d failures", results_seen, failures);
        if (failures == 0) begin
            $display("diff_drive_wheel_speed_p_control_tb: PASS");
        end else begin
            $display("diff_drive_wheel_speed_p_control_tb: FAIL");
        end
        $finish;
    end

endmodule
